@@ hdl/bc4_pkg.sv @@
package bc4_pkg;

   localparam int TEXEL_W    = 8;
   localparam int BLK_ROWS   = 4;
   localparam int BLK_COLS   = 4;
   localparam int SEL_W      = 3;
   localparam int PAL_SIZE   = 8;
   localparam int SELECTOR_W = BLK_ROWS * BLK_COLS * SEL_W;
   localparam int ROW_W      = BLK_COLS * TEXEL_W;
   localparam int ROW_IDX_W  = 2;

   localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(BLK_ROWS - 1);

   typedef logic [TEXEL_W-1:0] texel_type;
   typedef texel_type [PAL_SIZE-1:0] palette_type;
   typedef logic [BLK_ROWS-1:0][BLK_COLS-1:0][SEL_W-1:0] selector_type;

   typedef struct packed {
      texel_type    endpoint_a;
      texel_type    endpoint_b;
      selector_type selector_bits;
   } block_type;

endpackage

@@ hdl/bc4_req_if.sv @@
interface bc4_req_if import bc4_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TEXEL_W-1:0]    endpoint_a;
   logic [TEXEL_W-1:0]    endpoint_b;
   logic [SELECTOR_W-1:0] selector_bits;

   modport source (output valid, output endpoint_a, output endpoint_b,
                   output selector_bits, input ready);
   modport sink (input valid, input endpoint_a, input endpoint_b,
                 input selector_bits, output ready);
endinterface

@@ hdl/bc4_rsp_if.sv @@
interface bc4_rsp_if import bc4_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_W-1:0]     row_texels;
   logic [ROW_IDX_W-1:0] row_number;
   logic                 last_row;

   modport source (output valid, output row_texels, output row_number,
                   output last_row, input ready);
   modport sink (input valid, input row_texels, input row_number,
                 input last_row, output ready);
endinterface

@@ hdl/bc4_palette.sv @@
module bc4_palette import bc4_pkg::*; (
   input  texel_type   endpoint_a,
   input  texel_type   endpoint_b,
   output palette_type palette
);

   // x / 7 for x < 2048: multiply by ceil(2^15 / 7), error stays below 1/7
   localparam int DIV7_MUL   = 4682;
   localparam int DIV7_SHIFT = 15;
   // x / 5 for x < 2048: multiply by ceil(2^14 / 5)
   localparam int DIV5_MUL   = 3277;
   localparam int DIV5_SHIFT = 14;

   logic [10:0] sum7 [2:7];
   logic [23:0] prod7 [2:7];
   logic [10:0] sum5 [2:5];
   logic [22:0] prod5 [2:5];
   logic        a_greater;

   assign a_greater = endpoint_a > endpoint_b;

   always_comb begin
      for (int i = 2; i < 8; i++) begin
         sum7[i]  = 11'((8 - i) * endpoint_a) + 11'((i - 1) * endpoint_b);
         prod7[i] = 24'(sum7[i]) * 24'(DIV7_MUL);
      end
      for (int i = 2; i < 6; i++) begin
         sum5[i]  = 11'((6 - i) * endpoint_a) + 11'((i - 1) * endpoint_b);
         prod5[i] = 23'(sum5[i]) * 23'(DIV5_MUL);
      end
   end

   always_comb begin
      palette[0] = endpoint_a;
      palette[1] = endpoint_b;
      if (a_greater) begin
         for (int i = 2; i < 8; i++) begin
            palette[i] = prod7[i][DIV7_SHIFT +: TEXEL_W];
         end
      end else begin
         for (int i = 2; i < 6; i++) begin
            palette[i] = prod5[i][DIV5_SHIFT +: TEXEL_W];
         end
         palette[6] = '0;
         palette[7] = '1;
      end
   end

endmodule

@@ hdl/bc4_row_sequencer.sv @@
module bc4_row_sequencer import bc4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          blk_valid,
   input  palette_type   palette,
   input  selector_type  selectors,
   output logic          blk_load,
   bc4_rsp_if.source     rsp_chan
);

   palette_type          pal_ff, pal_in;
   selector_type         sel_ff, sel_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic                 busy_ff, busy_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]     out_texels_ff, out_texels_in;
   logic [ROW_IDX_W-1:0] out_row_ff, out_row_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_free;
   logic                 fire;
   logic                 at_last;

   always_comb begin
      out_free = !out_valid_ff || rsp_chan.ready;
      fire     = busy_ff && out_free;
      at_last  = row_ff == LAST_ROW;
      blk_load = blk_valid && (!busy_ff || (fire && at_last));

      pal_in  = blk_load ? palette : pal_ff;
      sel_in  = blk_load ? selectors : sel_ff;
      busy_in = busy_ff;
      row_in  = row_ff;
      if (blk_load) begin
         busy_in = 1'b1;
         row_in  = '0;
      end else if (fire) begin
         busy_in = !at_last;
         row_in  = row_ff + 1'b1;
      end

      // one row of palette lookups per transaction
      for (int col = 0; col < BLK_COLS; col++) begin
         out_texels_in[col*TEXEL_W +: TEXEL_W] = pal_ff[sel_ff[row_ff][col]];
      end
      out_row_in  = row_ff;
      out_last_in = at_last;
      if (!fire) begin
         out_texels_in = out_texels_ff;
         out_row_in    = out_row_ff;
         out_last_in   = out_last_ff;
      end
      out_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      pal_ff        <= pal_in;
      sel_ff        <= sel_in;
      out_texels_ff <= out_texels_in;
      out_row_ff    <= out_row_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         row_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.row_texels = out_texels_ff;
   assign rsp_chan.row_number = out_row_ff;
   assign rsp_chan.last_row   = out_last_ff;

endmodule

@@ hdl/bc4_block_decoder.sv @@
// path: block register, palette and selector registers, then the output register
// throughput: one row per cycle while the response channel is ready, set by the
// row sequencer emitting the four rows of a block one after another
// reset: synchronous, active high; clears the valid flags, busy flag and row
// counter, nothing else holds state between blocks
module bc4_block_decoder import bc4_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bc4_req_if.sink   req_chan,
   bc4_rsp_if.source rsp_chan
);

   block_type   block_ff, block_in;
   logic        blk_valid_ff, blk_valid_in;
   logic        blk_load;
   logic        req_fire;
   palette_type palette;

   assign req_chan.ready = !blk_valid_ff || blk_load;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      block_in = block_ff;
      if (req_fire) begin
         block_in.endpoint_a    = req_chan.endpoint_a;
         block_in.endpoint_b    = req_chan.endpoint_b;
         block_in.selector_bits = req_chan.selector_bits;
      end
      blk_valid_in = req_fire ? 1'b1 : (blk_load ? 1'b0 : blk_valid_ff);
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      if (reset) begin
         blk_valid_ff <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
      end
   end

   bc4_palette u_palette (
      .endpoint_a (block_ff.endpoint_a),
      .endpoint_b (block_ff.endpoint_b),
      .palette    (palette)
   );

   bc4_row_sequencer u_row_sequencer (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid_ff),
      .palette   (palette),
      .selectors (block_ff.selector_bits),
      .blk_load  (blk_load),
      .rsp_chan  (rsp_chan)
   );

endmodule
